### rtl/assert_macros.svh
// Assertion macros used by the checker file.
// Depends on nothing; the user supplies the clock and reset names.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge, skipped while reset is high.
`define ASSERT_CLK(label, clk_sig, rst_sig, prop) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) (prop)) \
    else $error("assertion failed");

// Check a property on every rising edge, reset included.
`define ASSERT_ALWAYS(label, clk_sig, prop) \
  label: assert property (@(posedge clk_sig) (prop)) \
    else $error("assertion failed");

`endif

### rtl/pcg_pkg.sv
// Constants, action codes and the output permutation of the PCG32 generator.
// Depends on nothing; used by every RTL module of the block.
package pcg_pkg;

  localparam logic [63:0] PCG_MULT = 64'd6364136223846793005;
  localparam logic [63:0] PCG_INC  = 64'd1442695040888963407;
  localparam logic [63:0] PCG_RESET_STATE = PCG_INC * PCG_MULT + PCG_INC;

  localparam int XS_SHIFT_A = 18;
  localparam int XS_SHIFT_B = 27;
  localparam int ROT_LSB    = 59;

  localparam logic [1:0] ACT_RAW     = 2'd0;
  localparam logic [1:0] ACT_BOUNDED = 2'd1;
  localparam logic [1:0] ACT_RESEED  = 2'd2;

  // XSH-RR output word of a state.
  function automatic logic [31:0] pcg_out(input logic [63:0] s);
    logic [63:0] xs_wide;
    logic [31:0] xs;
    logic [4:0]  rot;
    logic [63:0] dbl;
    xs_wide = ((s >> XS_SHIFT_A) ^ s) >> XS_SHIFT_B;
    xs      = xs_wide[31:0];
    rot     = s[63:ROT_LSB];
    dbl     = {xs, xs} >> rot;
    return dbl[31:0];
  endfunction

endpackage

### rtl/pcg_lcg_mul.sv
// LCG step unit: result = opnd * PCG_MULT + PCG_INC mod 2^64, one 32x32 product a cycle.
// Depends on pcg_pkg.
module pcg_lcg_mul
  import pcg_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] opnd,
  output logic        done,
  output logic [63:0] result
);

  logic        busy;
  logic [1:0]  step;
  logic [63:0] a;
  logic [63:0] acc;
  logic [63:0] prod;
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] mul_p;

  always_comb begin
    case (step)
      2'd0: begin
        mul_a = a[31:0];
        mul_b = PCG_MULT[31:0];
      end
      2'd1: begin
        mul_a = a[31:0];
        mul_b = PCG_MULT[63:32];
      end
      2'd2: begin
        mul_a = a[63:32];
        mul_b = PCG_MULT[31:0];
      end
      default: begin
        mul_a = 32'd0;
        mul_b = 32'd0;
      end
    endcase
  end

  assign mul_p = {32'd0, mul_a} * {32'd0, mul_b};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= 2'd0;
    end else if (start) begin
      busy <= 1'b1;
      step <= 2'd0;
    end else if (busy) begin
      step <= step + 2'd1;
      if (step == 2'd3) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a <= opnd;
    end else if (busy) begin
      prod <= mul_p;
      case (step)
        2'd1:    acc <= prod + PCG_INC;
        2'd2:    acc <= acc + {prod[31:0], 32'd0};
        default: acc <= acc;
      endcase
    end
  end

  assign done   = busy && (step == 2'd3);
  assign result = acc + {prod[31:0], 32'd0};

endmodule

### rtl/pcg_div32.sv
// Restoring remainder unit for 32-bit words, one quotient bit a cycle.
// Depends on pcg_pkg only through the shared import convention.
module pcg_div32
  import pcg_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [31:0] rem
);

  logic        busy;
  logic [4:0]  cnt;
  logic [31:0] q;
  logic [31:0] d;
  logic [32:0] shifted;
  logic [32:0] trial;

  assign shifted = {rem, q[31]};
  assign trial   = shifted - {1'b0, d};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= 5'd0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 5'd0;
      end else if (busy) begin
        cnt <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q   <= dividend;
      d   <= divisor;
      rem <= 32'd0;
    end else if (busy) begin
      q <= {q[30:0], 1'b0};
      if (!trial[32]) begin
        rem <= trial[31:0];
      end else begin
        rem <= shifted[31:0];
      end
    end
  end

endmodule

### rtl/pcg32_bounded_random.sv
// PCG32 XSH-RR generator with raw, bounded and reseed actions.
// Depends on pcg_pkg, pcg_lcg_mul and pcg_div32.
//
//   channel  handshake             payload
//   in       in_valid / in_stall   action, bound_min, bound_max
//   out      out_valid / out_stall value
//   seed     seed_valid / seed_ready seed_value
//
// Raw draw and reseed are bound by the LCG multiplier.
// Bounded draw with one draw: two remainder passes (threshold, then result),
// the draw and the hand-over; each redraw adds a draw; an empty range only hands over.
// Reset is synchronous and loads the state seeded from zero.
// in_stall stays high from a transfer until its result is in the output register;
// a stalled result holds that register and the sequencer waits.
module pcg32_bounded_random
  import pcg_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  action,
  input  logic [31:0] bound_min,
  input  logic [31:0] bound_max,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] value,
  input  logic        seed_valid,
  output logic        seed_ready,
  input  logic [63:0] seed_value
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_LCG,
    S_THR,
    S_DRAW,
    S_REM,
    S_OUT
  } fsm_t;

  fsm_t        fsm;
  logic [63:0] seed;
  logic [63:0] gen;
  logic [1:0]  act;
  logic [31:0] bmin;
  logic [31:0] rng;
  logic [31:0] thr;
  logic [31:0] word;
  logic [31:0] res;
  logic [31:0] rng_in;
  logic        in_xfer;

  logic        mul_start;
  logic [63:0] mul_opnd;
  logic        mul_done;
  logic [63:0] mul_result;
  logic        div_start;
  logic [31:0] div_dividend;
  logic [31:0] div_divisor;
  logic        div_done;
  logic [31:0] div_rem;

  assign in_stall   = (fsm != S_IDLE);
  assign in_xfer    = in_valid && !in_stall;
  assign seed_ready = 1'b1;
  assign rng_in     = bound_max - bound_min;

  always_ff @(posedge clk) begin
    if (rst) begin
      seed <= 64'd0;
    end else if (seed_valid && seed_ready) begin
      seed <= seed_value;
    end
  end

  always_comb begin
    mul_start    = 1'b0;
    mul_opnd     = gen;
    div_start    = 1'b0;
    div_dividend = word;
    div_divisor  = rng;
    case (fsm)
      S_IDLE: begin
        if (in_xfer) begin
          case (action)
            ACT_RAW: mul_start = 1'b1;
            ACT_RESEED: begin
              mul_start = 1'b1;
              mul_opnd  = seed + PCG_INC;
            end
            ACT_BOUNDED: begin
              if (rng_in != 32'd0) begin
                div_start    = 1'b1;
                div_dividend = 32'd0 - rng_in;
                div_divisor  = rng_in;
              end
            end
            default: ;
          endcase
        end
      end
      S_DRAW: mul_start = 1'b1;
      S_LCG: begin
        if (mul_done && (act == ACT_BOUNDED) && (word >= thr)) begin
          div_start = 1'b1;
        end
      end
      default: ;
    endcase
  end

  pcg_lcg_mul u_mul (
    .clk    (clk),
    .rst    (rst),
    .start  (mul_start),
    .opnd   (mul_opnd),
    .done   (mul_done),
    .result (mul_result)
  );

  pcg_div32 u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .rem      (div_rem)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      fsm       <= S_IDLE;
      out_valid <= 1'b0;
      gen       <= PCG_RESET_STATE;
    end else begin
      if ((fsm == S_OUT) && (!out_valid || !out_stall)) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (fsm)
        S_IDLE: begin
          if (in_xfer) begin
            act  <= action;
            bmin <= bound_min;
            rng  <= rng_in;
            word <= pcg_out(gen);
            case (action)
              ACT_RAW:    fsm <= S_LCG;
              ACT_RESEED: fsm <= S_LCG;
              ACT_BOUNDED: begin
                if (rng_in == 32'd0) begin
                  res <= bound_min;
                  fsm <= S_OUT;
                end else begin
                  fsm <= S_THR;
                end
              end
              default: begin
                res <= 32'd0;
                fsm <= S_OUT;
              end
            endcase
          end
        end
        S_THR: begin
          if (div_done) begin
            thr <= div_rem;
            fsm <= S_DRAW;
          end
        end
        S_DRAW: begin
          word <= pcg_out(gen);
          fsm  <= S_LCG;
        end
        S_LCG: begin
          if (mul_done) begin
            gen <= mul_result;
            case (act)
              ACT_RAW: begin
                res <= word;
                fsm <= S_OUT;
              end
              ACT_BOUNDED: begin
                if (word >= thr) begin
                  fsm <= S_REM;
                end else begin
                  fsm <= S_DRAW;
                end
              end
              default: begin
                res <= 32'd0;
                fsm <= S_OUT;
              end
            endcase
          end
        end
        S_REM: begin
          if (div_done) begin
            res <= div_rem + bmin;
            fsm <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid || !out_stall) begin
            value <= res;
            fsm   <= S_IDLE;
          end
        end
        default: fsm <= S_IDLE;
      endcase
    end
  end

endmodule

### rtl/pcg_checker.sv
// Port-level checks on the PCG32 block, bound to its top level.
// Depends on assert_macros.svh and pcg_pkg.
`include "assert_macros.svh"

module pcg_checker
  import pcg_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] value
);

  `ASSERT_ALWAYS(a_reset_clears, clk, rst |=> (!out_valid && !in_stall))
  `ASSERT_CLK(a_busy_after_xfer, clk, rst, (in_valid && !in_stall) |=> in_stall)
  `ASSERT_CLK(a_result_from_busy, clk, rst, $rose(out_valid) |-> $past(in_stall))
  `ASSERT_CLK(a_out_hold, clk, rst, (out_valid && out_stall) |=> (out_valid && $stable(value)))

endmodule

bind pcg32_bounded_random pcg_checker u_pcg_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .value     (value)
);

### test/pcg32_bounded_random_test.sv
// Self-checking bench for pcg32_bounded_random: raw, bounded, reseed and unused actions,
// with results predicted by a local PCG32 model under random valid/stall pressure.
// Depends on pcg_pkg for the generator constants and action codes.
module pcg32_bounded_random_test;
  import pcg_pkg::*;

  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int CHUNK_ITEMS = 326;
  localparam int PRINT_CAP = 40;

  typedef struct packed {
    logic [1:0]  act;
    logic [31:0] lo;
    logic [31:0] hi;
  } request_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  action = ACT_RAW;
  logic [31:0] bound_min = '0;
  logic [31:0] bound_max = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] value;
  logic        seed_valid = 1'b0;
  logic        seed_ready;
  logic [63:0] seed_value = '0;

  request_t    pending_requests[$];
  logic [31:0] expected_values[$];
  logic [63:0] lcg_state = PCG_RESET_STATE;
  logic [63:0] seed_shadow = '0;
  int          tx_idle_pct = 11;
  int          rx_idle_pct = 63;
  int          failures = 0;
  int          cycle_count = 0;

  pcg32_bounded_random dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .action(action), .bound_min(bound_min), .bound_max(bound_max),
    .out_valid(out_valid), .out_stall(out_stall), .value(value),
    .seed_valid(seed_valid), .seed_ready(seed_ready), .seed_value(seed_value)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Output word of the current state; the state then advances one LCG step.
  function automatic logic [31:0] pcg_word_next();
    logic [63:0] s;
    logic [31:0] xs;
    logic [5:0]  rot;
    s = lcg_state;
    lcg_state = s * PCG_MULT + PCG_INC;
    xs = 32'((s ^ (s >> 18)) >> 27);
    rot = {1'b0, s[63:59]};
    return (xs >> rot) | (xs << (6'd32 - rot));
  endfunction

  function automatic logic [31:0] bounded_result(logic [31:0] lo, logic [31:0] hi);
    logic [31:0] span;
    logic [31:0] floor_ok;
    logic [31:0] w;
    span = hi - lo;
    if (span == 32'd0) return lo;
    floor_ok = (32'd0 - span) % span;
    w = pcg_word_next();
    while (w < floor_ok) w = pcg_word_next();
    return (w % span) + lo;
  endfunction

  function automatic logic [31:0] predict_value(request_t r);
    case (r.act)
      ACT_RAW:     return pcg_word_next();
      ACT_BOUNDED: return bounded_result(r.lo, r.hi);
      ACT_RESEED: begin
        lcg_state = (seed_shadow + PCG_INC) * PCG_MULT + PCG_INC;
        return 32'd0;
      end
      default:     return 32'd0;
    endcase
  endfunction

  task automatic flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
    failures++;
    if (failures <= PRINT_CAP)
      $display("%0t: %s: value %h, expected %h", $time, what, got, want);
  endtask

  always @(posedge clk) begin : drive_requests
    request_t req;
    if (rst) begin
      in_valid <= 1'b0;
      lcg_state = PCG_RESET_STATE;
    end else begin
      if (in_valid && !in_stall)
        expected_values.push_back(predict_value({action, bound_min, bound_max}));
      if (!in_valid || !in_stall) begin
        if (pending_requests.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
          req = pending_requests.pop_front();
          in_valid  <= 1'b1;
          action    <= req.act;
          bound_min <= req.lo;
          bound_max <= req.hi;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : check_values
    logic [31:0] want;
    out_stall <= ($urandom_range(99) < rx_idle_pct);
    if (!rst && out_valid && !out_stall) begin
      if (expected_values.size() == 0) begin
        flag_mismatch("unexpected transfer", value, 32'd0);
      end else begin
        want = expected_values.pop_front();
        if (value !== want) flag_mismatch("value mismatch", value, want);
      end
    end
  end

  task automatic push_request(logic [1:0] act, logic [31:0] lo, logic [31:0] hi);
    pending_requests.push_back({act, lo, hi});
  endtask

  function automatic request_t random_request();
    request_t r;
    int pick;
    pick = $urandom_range(99);
    r.act = pick < 30 ? ACT_RAW : pick < 78 ? ACT_BOUNDED : pick < 90 ? ACT_RESEED : ACT_UNUSED;
    r.lo = $urandom;
    case ($urandom_range(7))
      0: r.hi = r.lo;
      1: r.hi = r.lo + $urandom_range(1, 16);
      2: r.hi = r.lo + 32'h8000_0000 + $urandom_range(0, 255);
      3: r.hi = r.lo + (32'd1 << $urandom_range(0, 31));
      4: r.hi = r.lo - $urandom_range(1, 16);
      5: begin
        r.lo = 32'd0;
        r.hi = $urandom_range(1, 1000);
      end
      default: r.hi = $urandom;
    endcase
    return r;
  endfunction

  task automatic write_seed(logic [63:0] v);
    @(posedge clk);
    seed_valid <= 1'b1;
    seed_value <= v;
    do @(posedge clk); while (!seed_ready);
    seed_shadow = v;
    seed_valid <= 1'b0;
  endtask

  // Sample away from the rising edge so every transfer of that edge has settled.
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_requests.size() != 0 || in_valid || expected_values.size() != 0);
  endtask

  initial begin
    logic [63:0] seeds[5];
    seeds[0] = '1;
    seeds[1] = '0;
    seeds[2] = {$urandom, $urandom};
    seeds[3] = 64'h8000_0000_0000_0000;
    seeds[4] = {$urandom, $urandom};

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // reset state first, then the edges of the bounds, then a reseed from the reset seed
    push_request(ACT_RAW, 32'd0, 32'd0);
    push_request(ACT_RAW, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_request(ACT_BOUNDED, 32'd0, 32'd0);
    push_request(ACT_BOUNDED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_request(ACT_BOUNDED, 32'd0, 32'd1);
    push_request(ACT_BOUNDED, 32'd0, 32'hFFFF_FFFF);
    push_request(ACT_BOUNDED, 32'hFFFF_FFFF, 32'd0);
    push_request(ACT_BOUNDED, 32'd10, 32'd5);
    push_request(ACT_BOUNDED, 32'd0, 32'h8000_0001);
    push_request(ACT_BOUNDED, 32'h8000_0000, 32'h7FFF_FFFF);
    push_request(ACT_BOUNDED, 32'd0, 32'h8000_0000);
    push_request(ACT_BOUNDED, 32'hFFFF_FFFB, 32'd5);
    push_request(ACT_BOUNDED, 32'h7FFF_FFFF, 32'h8000_0000);
    push_request(ACT_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_request(ACT_RESEED, 32'd0, 32'd0);
    push_request(ACT_RAW, 32'd0, 32'd0);
    push_request(ACT_RAW, 32'd0, 32'd0);
    push_request(ACT_BOUNDED, 32'd100, 32'd200);
    push_request(ACT_UNUSED, 32'd0, 32'd0);
    push_request(ACT_RESEED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_request(ACT_BOUNDED, 32'd0, 32'd3);
    push_request(ACT_BOUNDED, 32'hC000_0000, 32'h4000_0001);
    wait_drained();

    for (int chunk = 0; chunk < 5; chunk++) begin
      tx_idle_pct = chunk < 2 ? 11 : chunk < 4 ? 63 : 0;
      rx_idle_pct = chunk < 2 ? 63 : chunk < 4 ? 11 : 0;
      write_seed(seeds[chunk]);
      push_request(ACT_RESEED, $urandom, $urandom);
      for (int i = 0; i < CHUNK_ITEMS; i++)
        pending_requests.push_back(random_request());
      wait_drained();
    end

    repeat (200) @(posedge clk);
    if (failures == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
